// ===== src/tpfd_pkg.sv =====
// Shared constants and operation codes for the two-priority frame deque.
`default_nettype none
package tpfd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FRAME_W     = 48;
    localparam int PRIO_BIT    = FRAME_W - 1;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [FRAME_W-1:0] frame_t;

endpackage
`default_nettype wire

// ===== src/tpfd_req_if.sv =====
// Request channel: operation code and frame, with valid/ready handshake.
`default_nettype none
interface tpfd_req_if;
    import tpfd_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    frame_t frame_in;

    modport source (output valid, output op, output frame_in, input ready);
    modport sink   (input valid, input op, input frame_in, output ready);
endinterface
`default_nettype wire

// ===== src/tpfd_rsp_if.sv =====
// Response channel: status and dequeued frame, with valid/ready handshake.
`default_nettype none
interface tpfd_rsp_if;
    import tpfd_pkg::*;

    logic   valid;
    logic   ready;
    logic   ok;
    frame_t frame_out;

    modport source (output valid, output ok, output frame_out, input ready);
    modport sink   (input valid, input ok, input frame_out, output ready);
endinterface
`default_nettype wire

// ===== src/two_priority_frame_deque.sv =====
// Two-priority frame deque: circular store of 48-bit frames with head/tail insert.
//
// Usage:
//   req carries one operation per transfer: op selects enqueue of frame_in or
//   dequeue of the head frame. A frame with bit 47 set is inserted at the head,
//   otherwise at the tail. An enqueue into a full deque is refused.
//   rsp returns exactly one result per request: ok, plus the dequeued frame
//   (zero for an enqueue or a refused dequeue).
//   The result is registered and appears on rsp in the cycle after the request transfer.
//   Throughput: one operation per cycle while rsp takes results; the pointer update and
//   the single slot access both fit between the request edge and the result register.
//   The result register is the only buffer: while rsp is stalled with a
//   result pending, req.ready is low; it rises again in the cycle the result
//   is taken, so back-to-back transfers continue through a draining output.
//   Reset (rst_n low, asynchronous) empties the deque and drops any pending
//   result. Frame slots are not cleared; only written slots are ever read.
`default_nettype none
module two_priority_frame_deque (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tpfd_req_if.sink   req,
    tpfd_rsp_if.source rsp
);
    import tpfd_pkg::*;

    frame_t store_mem [QUEUE_DEPTH];

    idx_t   head_reg, head_next;
    idx_t   tail_reg, tail_next;
    logic   empty_reg, empty_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   ok_reg, ok_next;
    frame_t frame_out_reg, frame_out_next;

    logic   accept;
    logic   wr_en;
    logic   rd_en;
    idx_t   wr_addr;
    idx_t   head_inc;
    idx_t   head_dec;
    idx_t   tail_inc;
    logic   full;

    assign req.ready     = !rsp_valid_reg || rsp.ready;
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.ok        = ok_reg;
    assign rsp.frame_out = frame_out_reg;

    // Wrap at the deque depth, which need not be a power of two
    assign head_inc = (head_reg == idx_t'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? idx_t'(QUEUE_DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == idx_t'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign full     = !empty_reg && (tail_inc == head_reg);

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        wr_addr        = '0;
        ok_next        = ok_reg;
        frame_out_next = frame_out_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            ok_next        = 1'b0;
            frame_out_next = '0;
            if (req.op == OP_ENQUEUE)
            begin
                if (empty_reg)
                begin
                    // First frame always lands in slot zero
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    ok_next    = 1'b1;
                end
                else if (!full)
                begin
                    wr_en   = 1'b1;
                    ok_next = 1'b1;
                    if (req.frame_in[PRIO_BIT])
                    begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                    else
                    begin
                        tail_next = tail_inc;
                        wr_addr   = tail_inc;
                    end
                end
            end
            else if (!empty_reg)
            begin
                ok_next = 1'b1;
                rd_en   = 1'b1;
                // Last frame out: keep pointers, mark empty
                if (head_reg == tail_reg)
                    empty_next = 1'b1;
                else
                    head_next = head_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Load the head slot straight into the result register on a dequeue
    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        if (rd_en)
            frame_out_reg <= store_mem[head_reg];
        else
            frame_out_reg <= frame_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= req.frame_in;
    end

    // An empty deque always has head and tail on the same slot
    assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == tail_reg))
        else $error("empty deque with head and tail apart");

    // An accepted enqueue never leaves the deque empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.op == OP_ENQUEUE)) |=> !empty_reg)
        else $error("deque empty after enqueue");

    // A dequeue from an empty deque must fail with a zero frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.op == OP_DEQUEUE) && empty_reg)
            |=> (rsp.valid && !rsp.ok && (rsp.frame_out == '0)))
        else $error("dequeue from empty deque reported success");

    // An enqueue into a full deque must fail and leave the pointers alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.op == OP_ENQUEUE) && full)
            |=> (!rsp.ok && $stable(head_reg) && $stable(tail_reg)))
        else $error("enqueue into full deque was taken");

endmodule
`default_nettype wire

// ===== sim/two_priority_frame_deque_tb.sv =====
// Testbench for the two-priority frame deque: directed and random ops against a predictor.
`timescale 1ns / 100ps
module two_priority_frame_deque_tb;
    import tpfd_pkg::*;

    typedef struct packed {
        logic   ok;
        frame_t frame;
    } deque_rsp_t;

    logic clk;
    logic rst_n;

    tpfd_req_if req_bus ();
    tpfd_rsp_if rsp_bus ();

    two_priority_frame_deque dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Predicted deque contents
    frame_t     mdl_slots [QUEUE_DEPTH];
    idx_t       mdl_head;
    idx_t       mdl_tail;
    logic       mdl_empty;

    deque_rsp_t pending_rsp [$];
    int         error_count;

    logic       src_idle_on;
    logic       sink_stall_on;
    int         rsp_hold_len;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic idx_t idx_next(input idx_t i);
        return (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic idx_t idx_prev(input idx_t i);
        return (i == '0) ? idx_t'(QUEUE_DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic deque_rsp_t deque_apply(input logic op, input frame_t frame);
        deque_rsp_t r;
        r.ok    = 1'b0;
        r.frame = '0;
        if (op == OP_ENQUEUE)
        begin
            if (mdl_empty)
            begin
                // Empty deque: restart both pointers at slot zero
                mdl_head     = '0;
                mdl_tail     = '0;
                mdl_slots[0] = frame;
                mdl_empty    = 1'b0;
                r.ok         = 1'b1;
            end
            else if (idx_next(mdl_tail) == mdl_head)
            begin
                r.ok = 1'b0;
            end
            else if (frame[PRIO_BIT])
            begin
                mdl_head            = idx_prev(mdl_head);
                mdl_slots[mdl_head] = frame;
                r.ok                = 1'b1;
            end
            else
            begin
                mdl_tail            = idx_next(mdl_tail);
                mdl_slots[mdl_tail] = frame;
                r.ok                = 1'b1;
            end
        end
        else if (!mdl_empty)
        begin
            r.frame = mdl_slots[mdl_head];
            if (mdl_head == mdl_tail)
                mdl_empty = 1'b1;
            else
                mdl_head = idx_next(mdl_head);
            r.ok = 1'b1;
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic frame_t rand_frame();
        frame_t      f;
        logic [31:0] hi_word;
        hi_word      = $urandom;
        f[31:0]      = $urandom;
        f[47:32]     = hi_word[15:0];
        return f;
    endfunction

    // Offer one request and hold it until the transfer; valid stays high on return
    task automatic send_req(input logic op, input frame_t frame);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.op       <= op;
        req_bus.frame_in <= frame;
        do
            @(posedge clk);
        while (!req_bus.ready);
        pending_rsp.push_back(deque_apply(op, frame));
    endtask

    task automatic run_random_ops(input int count);
        int done;
        int burst;
        int enq_pct;
        int k;
        done = 0;
        while (done < count)
        begin
            // Bias each burst so the deque swings between full and empty
            burst = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                default: enq_pct = 80;
            endcase
            for (k = 0; k < burst && done < count; k++)
            begin
                if ($urandom_range(0, 99) < enq_pct)
                    send_req(OP_ENQUEUE, rand_frame());
                else
                    send_req(OP_DEQUEUE, rand_frame());
                done++;
            end
        end
    endtask

    task automatic test_directed();
        frame_t f;
        int     k;
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        send_req(OP_DEQUEUE, 48'hFFFF_FFFF_FFFF);   // dequeue from empty
        send_req(OP_ENQUEUE, 48'h0000_0000_0000);   // low priority into empty
        send_req(OP_ENQUEUE, 48'hFFFF_FFFF_FFFF);   // high priority goes ahead
        send_req(OP_DEQUEUE, 48'h0000_0000_0000);
        send_req(OP_DEQUEUE, 48'h0000_0000_0000);   // last frame out
        send_req(OP_ENQUEUE, 48'h8000_0000_0000);   // high priority into empty
        for (k = 0; k < QUEUE_DEPTH - 1; k++)
        begin
            f = rand_frame();
            f[PRIO_BIT] = k[0];
            if (k == 0)
                f = 48'h7FFF_FFFF_FFFF;
            send_req(OP_ENQUEUE, f);
        end
        send_req(OP_ENQUEUE, 48'h7FFF_FFFF_FFFF);   // refused, full
        send_req(OP_ENQUEUE, 48'hFFFF_FFFF_FFFF);   // refused, full
        send_req(OP_DEQUEUE, 48'h0000_0000_0000);
        send_req(OP_ENQUEUE, 48'hC000_0000_0001);   // refill at head
    endtask

    task automatic test_random_back_to_back();
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        run_random_ops(300);
    endtask

    task automatic test_random_idle();
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        run_random_ops(1500);
    endtask

    task automatic test_output_backpressure();
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b1;
        rsp_hold_len  = 300;
        run_random_ops(200);
    endtask

    // Response ready: random stalls, plus one long hold-off on request
    initial
    begin : rsp_ready_drive
        int len;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_len > 0)
            begin
                len          = rsp_hold_len;
                rsp_hold_len = 0;
                rsp_bus.ready <= 1'b0;
                repeat (len) @(posedge clk);
            end
            else if (sink_stall_on && $urandom_range(0, 99) < 20)
            begin
                len = pick_gap();
                rsp_bus.ready <= 1'b0;
                repeat (len) @(posedge clk);
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin : rsp_checker
        deque_rsp_t exp_rsp;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("unexpected result transfer: ok %0d, frame_out %h",
                           rsp_bus.ok, rsp_bus.frame_out);
                    error_count++;
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    if (rsp_bus.ok !== exp_rsp.ok)
                    begin
                        $error("ok mismatch: expected %0d, actual %0d",
                               exp_rsp.ok, rsp_bus.ok);
                        error_count++;
                    end
                    if (rsp_bus.frame_out !== exp_rsp.frame)
                    begin
                        $error("frame_out mismatch: expected %h, actual %h",
                               exp_rsp.frame, rsp_bus.frame_out);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        error_count   = 0;
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        rsp_hold_len  = 0;
        mdl_head      = '0;
        mdl_tail      = '0;
        mdl_empty     = 1'b1;
        foreach (mdl_slots[i])
            mdl_slots[i] = '0;
        rst_n            <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.op       <= OP_ENQUEUE;
        req_bus.frame_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_back_to_back();
        test_random_idle();
        test_output_backpressure();
        req_bus.valid <= 1'b0;

        // Drain outstanding results, then keep watching for stray ones
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
